>>> sv/lrs_pkg.sv
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared types, constants and the crc helper for the latest record scanner.
// ----------------------------------------------------------------------------
package lrs_pkg;

   localparam int SLOT_BYTES_DEF = 32;
   localparam int MAX_SLOTS_DEF  = 256;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_TOP  = 16'h8000;
   localparam logic [7:0]  CRC_SPAN = 8'd18;

   // byte offsets within a slot
   localparam logic [7:0] OFS_MAGIC_HI = 8'd3;
   localparam logic [7:0] OFS_SEQ      = 8'd4;
   localparam logic [7:0] OFS_VERSION  = 8'd8;
   localparam logic [7:0] OFS_ATTEMPTS = 8'd9;
   localparam logic [7:0] OFS_LOCKOUT  = 8'd10;
   localparam logic [7:0] OFS_BOOTS    = 8'd14;
   localparam logic [7:0] OFS_CRC_LO   = 8'd18;
   localparam logic [7:0] OFS_CRC_HI   = 8'd19;

   // configuration register indexes
   localparam logic CSR_MAGIC   = 1'b0;
   localparam logic CSR_VERSION = 1'b1;

   typedef struct packed {
      logic        done;
      logic        ok;
      logic [31:0] sequence_num;
      logic [7:0]  attempts;
      logic [31:0] lockout;
      logic [31:0] boots;
   } slot_rec_type;

   typedef struct packed {
      logic        found;
      logic [7:0]  best_slot;
      logic [31:0] best_sequence;
      logic [7:0]  failed_attempts;
      logic [31:0] lockout_deadline;
      logic [31:0] boot_total;
      logic [8:0]  slots_scanned;
      logic [7:0]  next_slot;
      logic [31:0] next_sequence;
   } rsp_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> sv/lrs_if.sv
// ----------------------------------------------------------------------------
// lrs_req_if / lrs_rsp_if
// Valid/ready channels for image bytes and scan results.
// ----------------------------------------------------------------------------
interface lrs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] image_byte;
   logic       final_byte;

   modport source (output valid, output image_byte, output final_byte, input ready);
   modport sink   (input valid, input image_byte, input final_byte, output ready);
endinterface

interface lrs_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [7:0]  best_slot;
   logic [31:0] best_sequence;
   logic [7:0]  failed_attempts;
   logic [31:0] lockout_deadline;
   logic [31:0] boot_total;
   logic [8:0]  slots_scanned;
   logic [7:0]  next_slot;
   logic [31:0] next_sequence;

   modport source (output valid, output found, output best_slot, output best_sequence,
                   output failed_attempts, output lockout_deadline, output boot_total,
                   output slots_scanned, output next_slot, output next_sequence,
                   input ready);
   modport sink   (input valid, input found, input best_slot, input best_sequence,
                   input failed_attempts, input lockout_deadline, input boot_total,
                   input slots_scanned, input next_slot, input next_sequence,
                   output ready);
endinterface

>>> sv/lrs_slot_check.sv
// ----------------------------------------------------------------------------
// lrs_slot_check
// Per-byte slot decode: field capture, magic/version check and crc check.
// ----------------------------------------------------------------------------
module lrs_slot_check
   import lrs_pkg::*;
#(
   parameter int SLOT_BYTES = SLOT_BYTES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         take,
   input  logic         flush,
   input  logic [7:0]   image_byte,
   input  logic [31:0]  record_magic,
   input  logic [7:0]   record_version,
   output slot_rec_type rec
);

   localparam int OFF_W = $clog2(SLOT_BYTES);
   localparam logic [OFF_W-1:0] LAST_OFF = OFF_W'(SLOT_BYTES - 1);

   logic [OFF_W-1:0] off_ff, off_in;
   logic [15:0]      crc_ff, crc_in, crc_upd;
   logic             hdr_ff, hdr_in, hdr_upd;
   logic [31:0]      magic_ff, magic_in;
   logic [31:0]      seq_ff, seq_in;
   logic [7:0]       att_ff, att_in;
   logic [31:0]      lock_ff, lock_in;
   logic [31:0]      boots_ff, boots_in;
   logic [7:0]       crc_lo_ff, crc_lo_in;
   logic [7:0]       off8;
   logic [1:0]       lane_a, lane_b;
   logic             clear;

   assign off8   = 8'(off_ff);
   assign lane_a = off8[1:0];
   assign lane_b = 2'(off8[1:0] - 2'd2);

   always_comb begin
      crc_upd   = crc_ff;
      hdr_upd   = hdr_ff;
      magic_in  = magic_ff;
      seq_in    = seq_ff;
      att_in    = att_ff;
      lock_in   = lock_ff;
      boots_in  = boots_ff;
      crc_lo_in = crc_lo_ff;

      if (off8 < CRC_SPAN) begin
         crc_upd = crc_byte(crc_ff, image_byte);
      end

      if (off8 < OFS_SEQ) begin
         magic_in[{lane_a, 3'b000} +: 8] = image_byte;
         if (off8 == OFS_MAGIC_HI && {image_byte, magic_ff[23:0]} != record_magic) begin
            hdr_upd = 1'b0;
         end
      end else if (off8 < OFS_VERSION) begin
         seq_in[{lane_a, 3'b000} +: 8] = image_byte;
      end else if (off8 == OFS_VERSION) begin
         if (image_byte != record_version) begin
            hdr_upd = 1'b0;
         end
      end else if (off8 == OFS_ATTEMPTS) begin
         att_in = image_byte;
      end else if (off8 < OFS_BOOTS) begin
         lock_in[{lane_b, 3'b000} +: 8] = image_byte;
      end else if (off8 < OFS_CRC_LO) begin
         boots_in[{lane_b, 3'b000} +: 8] = image_byte;
      end else if (off8 == OFS_CRC_LO) begin
         crc_lo_in = image_byte;
      end else if (off8 == OFS_CRC_HI) begin
         if ({image_byte, crc_lo_ff} != crc_ff) begin
            hdr_upd = 1'b0;
         end
      end

      rec.done         = take && (off_ff == LAST_OFF);
      rec.ok           = hdr_upd;
      rec.sequence_num = seq_in;
      rec.attempts     = att_in;
      rec.lockout      = lock_in;
      rec.boots        = boots_in;

      clear = flush || rec.done;
      if (clear) begin
         off_in = '0;
         crc_in = CRC_INIT;
         hdr_in = 1'b1;
      end else if (take) begin
         off_in = off_ff + 1'b1;
         crc_in = crc_upd;
         hdr_in = hdr_upd;
      end else begin
         off_in = off_ff;
         crc_in = crc_ff;
         hdr_in = hdr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff <= '0;
         crc_ff <= CRC_INIT;
         hdr_ff <= 1'b1;
      end else begin
         off_ff <= off_in;
         crc_ff <= crc_in;
         hdr_ff <= hdr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         magic_ff  <= magic_in;
         seq_ff    <= seq_in;
         att_ff    <= att_in;
         lock_ff   <= lock_in;
         boots_ff  <= boots_in;
         crc_lo_ff <= crc_lo_in;
      end
   end

endmodule

>>> sv/lrs_rsp_queue.sv
// ----------------------------------------------------------------------------
// lrs_rsp_queue
// Result register with one skid entry; ready to the request side is registered.
// ----------------------------------------------------------------------------
module lrs_rsp_queue
   import lrs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  rsp_type   push_data,
   output logic      space,
   lrs_rsp_if.source rsp
);

   logic    head_v_ff, head_v_in;
   logic    skid_v_ff, skid_v_in;
   rsp_type head_ff, head_in;
   rsp_type skid_ff, skid_in;
   logic    pop;

   assign pop   = head_v_ff && rsp.ready;
   assign space = !skid_v_ff;

   always_comb begin
      head_v_in = head_v_ff;
      skid_v_in = skid_v_ff;
      head_in   = head_ff;
      skid_in   = skid_ff;
      if (pop) begin
         if (skid_v_ff) begin
            head_in   = skid_ff;
            skid_v_in = 1'b0;
         end else if (push) begin
            head_in = push_data;
         end else begin
            head_v_in = 1'b0;
         end
      end else if (!head_v_ff) begin
         if (push) begin
            head_in   = push_data;
            head_v_in = 1'b1;
         end
      end else if (push) begin
         skid_in   = push_data;
         skid_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         head_v_ff <= head_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid            = head_v_ff;
   assign rsp.found            = head_ff.found;
   assign rsp.best_slot        = head_ff.best_slot;
   assign rsp.best_sequence    = head_ff.best_sequence;
   assign rsp.failed_attempts  = head_ff.failed_attempts;
   assign rsp.lockout_deadline = head_ff.lockout_deadline;
   assign rsp.boot_total       = head_ff.boot_total;
   assign rsp.slots_scanned    = head_ff.slots_scanned;
   assign rsp.next_slot        = head_ff.next_slot;
   assign rsp.next_sequence    = head_ff.next_sequence;

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_v_ff)
      else $error("result pushed with skid entry full");

   a_skid_behind_head: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> head_v_ff)
      else $error("skid entry held without head entry");

endmodule

>>> sv/latest_record_scanner_top.sv
// ----------------------------------------------------------------------------
// latest_record_scanner_top
// Scans a slotted flash image byte by byte and reports the newest valid record.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    image_byte[7:0], final_byte
//   rsp      out  valid/ready    found .. next_sequence, one per final byte
//   csr      in   csr_wr_en      csr_index (0 magic, 1 version), csr_wr_data[31:0]
//
// One request per cycle while ready is high; accepted bytes fold into slot state.
// A final byte's result is registered in the result register or the skid entry.
// A result register plus one skid entry decouple the sides; ready drops only
// while both hold results.
// Synchronous reset clears scan state; magic and version reset to zero.
// ----------------------------------------------------------------------------
module latest_record_scanner_top
   import lrs_pkg::*;
#(
   parameter int SLOT_BYTES = SLOT_BYTES_DEF,
   parameter int MAX_SLOTS  = MAX_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   lrs_req_if.sink     req,
   lrs_rsp_if.source   rsp,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wr_data
);

   logic [31:0]  magic_ff;
   logic [7:0]   version_ff;
   logic [8:0]   count_ff, count_in, count_upd;
   logic         have_ff, have_in, have_upd;
   logic [7:0]   wslot_ff, wslot_in, wslot_upd;
   logic [31:0]  wseq_ff, wseq_in, wseq_upd;
   logic [7:0]   watt_ff, watt_in, watt_upd;
   logic [31:0]  wlock_ff, wlock_in, wlock_upd;
   logic [31:0]  wboots_ff, wboots_in, wboots_upd;
   logic         accept, take, space, push;
   logic [8:0]   slot_plus;
   slot_rec_type rec;
   rsp_type      result;

   assign accept = req.valid && req.ready;
   assign take   = accept && (count_ff < 9'(MAX_SLOTS));
   assign push   = accept && req.final_byte;
   assign req.ready = space;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff   <= '0;
         version_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MAGIC:   magic_ff   <= csr_wr_data;
            CSR_VERSION: version_ff <= csr_wr_data[7:0];
            default:     magic_ff   <= magic_ff;
         endcase
      end
   end

   lrs_slot_check #(
      .SLOT_BYTES (SLOT_BYTES)
   ) u_slot (
      .clock          (clock),
      .reset          (reset),
      .take           (take),
      .flush          (push),
      .image_byte     (req.image_byte),
      .record_magic   (magic_ff),
      .record_version (version_ff),
      .rec            (rec)
   );

   always_comb begin
      count_upd  = count_ff;
      have_upd   = have_ff;
      wslot_upd  = wslot_ff;
      wseq_upd   = wseq_ff;
      watt_upd   = watt_ff;
      wlock_upd  = wlock_ff;
      wboots_upd = wboots_ff;
      if (rec.done) begin
         if (rec.ok && (!have_ff || rec.sequence_num > wseq_ff)) begin
            have_upd   = 1'b1;
            wslot_upd  = count_ff[7:0];
            wseq_upd   = rec.sequence_num;
            watt_upd   = rec.attempts;
            wlock_upd  = rec.lockout;
            wboots_upd = rec.boots;
         end
         count_upd = count_ff + 9'd1;
      end

      // winner index is always below the slot count
      slot_plus = {1'b0, wslot_upd} + 9'd1;
      result.found            = have_upd;
      result.best_slot        = wslot_upd;
      result.best_sequence    = wseq_upd;
      result.failed_attempts  = watt_upd;
      result.lockout_deadline = wlock_upd;
      result.boot_total       = wboots_upd;
      result.slots_scanned    = count_upd;
      result.next_sequence    = wseq_upd + 32'd1;
      if (have_upd && slot_plus != count_upd) begin
         result.next_slot = slot_plus[7:0];
      end else begin
         result.next_slot = 8'd0;
      end

      if (push) begin
         count_in  = '0;
         have_in   = 1'b0;
         wslot_in  = '0;
         wseq_in   = '0;
         watt_in   = '0;
         wlock_in  = '0;
         wboots_in = '0;
      end else begin
         count_in  = count_upd;
         have_in   = have_upd;
         wslot_in  = wslot_upd;
         wseq_in   = wseq_upd;
         watt_in   = watt_upd;
         wlock_in  = wlock_upd;
         wboots_in = wboots_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         have_ff   <= 1'b0;
         wslot_ff  <= '0;
         wseq_ff   <= '0;
         watt_ff   <= '0;
         wlock_ff  <= '0;
         wboots_ff <= '0;
      end else begin
         count_ff  <= count_in;
         have_ff   <= have_in;
         wslot_ff  <= wslot_in;
         wseq_ff   <= wseq_in;
         watt_ff   <= watt_in;
         wlock_ff  <= wlock_in;
         wboots_ff <= wboots_in;
      end
   end

   lrs_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .space     (space),
      .rsp       (rsp)
   );

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 9'(MAX_SLOTS))
      else $error("slot count beyond limit");

   a_winner_below_count: assert property (@(posedge clock) disable iff (reset)
      have_ff |-> ({1'b0, wslot_ff} < count_ff))
      else $error("winner slot not below slot count");

   a_scan_cleared: assert property (@(posedge clock) disable iff (reset)
      push |=> (count_ff == 9'd0) && !have_ff)
      else $error("scan state not cleared after final byte");

endmodule

>>> verif/lrs_test_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lrs_test_pkg
// CRC-16/CCITT-FALSE step used both to build slot images and to predict
// which slots the scanner accepts.
// ----------------------------------------------------------------------------
package lrs_test_pkg;

   import lrs_pkg::CRC_POLY;

   // feeds one byte through the crc, msb first
   function automatic logic [15:0] crc_ccitt_next(input logic [15:0] acc,
                                                  input logic [7:0]  data);
      logic [15:0] r;
      logic        fb;
      r = acc;
      for (int i = 7; i >= 0; i--) begin
         fb = r[15] ^ data[i];
         r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return r;
   endfunction

endpackage

>>> verif/latest_record_scanner_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// latest_record_scanner_checker
// Follows every accepted image byte and register write, keeps its own slot
// and winner state, queues the scan report due on each final byte and
// compares it field by field with the report the scanner returns.
// ----------------------------------------------------------------------------
module latest_record_scanner_checker
   import lrs_pkg::*;
   import lrs_test_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   lrs_req_if          req_mon,
   lrs_rsp_if          rsp_mon,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wr_data,
   output int          mismatch_count,
   output int          scans_pending
);

   logic [31:0] magic_reg;
   logic [7:0]  version_reg;

   logic [4:0]  ofs;
   logic [8:0]  slot_count;
   logic [15:0] crc_acc;
   logic        slot_ok;
   logic [31:0] magic_acc;
   logic [31:0] seq_acc;
   logic [7:0]  att_acc;
   logic [31:0] lock_acc;
   logic [31:0] boots_acc;
   logic [7:0]  crc_low;

   logic        have_best;
   logic [7:0]  win_slot;
   logic [31:0] win_seq;
   logic [7:0]  win_att;
   logic [31:0] win_lock;
   logic [31:0] win_boots;

   rsp_type     scan_reports_due[$];

   task automatic clear_slot();
      ofs       = '0;
      crc_acc   = CRC_INIT;
      slot_ok   = 1'b1;
      magic_acc = '0;
      seq_acc   = '0;
      att_acc   = '0;
      lock_acc  = '0;
      boots_acc = '0;
      crc_low   = '0;
   endtask

   task automatic clear_scan();
      clear_slot();
      slot_count = '0;
      have_best  = 1'b0;
      win_slot   = '0;
      win_seq    = '0;
      win_att    = '0;
      win_lock   = '0;
      win_boots  = '0;
   endtask

   task automatic fold_byte(logic [7:0] b);
      if (ofs < CRC_SPAN) begin
         crc_acc = crc_ccitt_next(crc_acc, b);
      end
      if (ofs <= OFS_MAGIC_HI) begin
         magic_acc[8*int'(ofs) +: 8] = b;
         if (ofs == OFS_MAGIC_HI && magic_acc != magic_reg) begin
            slot_ok = 1'b0;
         end
      end else if (ofs < OFS_VERSION) begin
         seq_acc[8*(int'(ofs) - int'(OFS_SEQ)) +: 8] = b;
      end else if (ofs == OFS_VERSION) begin
         if (b != version_reg) begin
            slot_ok = 1'b0;
         end
      end else if (ofs == OFS_ATTEMPTS) begin
         att_acc = b;
      end else if (ofs < OFS_BOOTS) begin
         lock_acc[8*(int'(ofs) - int'(OFS_LOCKOUT)) +: 8] = b;
      end else if (ofs < OFS_CRC_LO) begin
         boots_acc[8*(int'(ofs) - int'(OFS_BOOTS)) +: 8] = b;
      end else if (ofs == OFS_CRC_LO) begin
         crc_low = b;
      end else if (ofs == OFS_CRC_HI) begin
         if ({b, crc_low} != crc_acc) begin
            slot_ok = 1'b0;
         end
      end

      if (int'(ofs) == SLOT_BYTES_DEF - 1) begin
         // earlier slot keeps the lead on equal sequence numbers
         if (slot_ok && (!have_best || seq_acc > win_seq)) begin
            have_best = 1'b1;
            win_slot  = slot_count[7:0];
            win_seq   = seq_acc;
            win_att   = att_acc;
            win_lock  = lock_acc;
            win_boots = boots_acc;
         end
         slot_count++;
         clear_slot();
      end else begin
         ofs++;
      end
   endtask

   task automatic note_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
         end
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type got;
      if (reset) begin
         clear_scan();
         magic_reg      = '0;
         version_reg    = '0;
         mismatch_count = 0;
         scan_reports_due.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_MAGIC) begin
               magic_reg = csr_wr_data;
            end else begin
               version_reg = csr_wr_data[7:0];
            end
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.found, rsp_mon.best_slot, rsp_mon.best_sequence,
                    rsp_mon.failed_attempts, rsp_mon.lockout_deadline,
                    rsp_mon.boot_total, rsp_mon.slots_scanned, rsp_mon.next_slot,
                    rsp_mon.next_sequence};
            if (scan_reports_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: scan report with no scan pending, slots_scanned %0d",
                           $time, got.slots_scanned);
               end
            end else begin
               want = scan_reports_due.pop_front();
               note_field("found", 32'(want.found), 32'(got.found));
               note_field("best_slot", 32'(want.best_slot), 32'(got.best_slot));
               note_field("best_sequence", want.best_sequence, got.best_sequence);
               note_field("failed_attempts", 32'(want.failed_attempts),
                          32'(got.failed_attempts));
               note_field("lockout_deadline", want.lockout_deadline, got.lockout_deadline);
               note_field("boot_total", want.boot_total, got.boot_total);
               note_field("slots_scanned", 32'(want.slots_scanned),
                          32'(got.slots_scanned));
               note_field("next_slot", 32'(want.next_slot), 32'(got.next_slot));
               note_field("next_sequence", want.next_sequence, got.next_sequence);
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            // bytes past the slot limit are dropped
            if (slot_count < MAX_SLOTS_DEF) begin
               fold_byte(req_mon.image_byte);
            end
            if (req_mon.final_byte) begin
               want.found            = have_best;
               want.best_slot        = win_slot;
               want.best_sequence    = win_seq;
               want.failed_attempts  = win_att;
               want.lockout_deadline = win_lock;
               want.boot_total       = win_boots;
               want.slots_scanned    = slot_count;
               want.next_slot        = (have_best && slot_count != 0) ?
                                       8'((int'(win_slot) + 1) % int'(slot_count)) : 8'd0;
               want.next_sequence    = win_seq + 32'd1;
               scan_reports_due.push_back(want);
               clear_scan();
            end
         end
      end
      scans_pending = scan_reports_due.size();
   end

endmodule

>>> verif/latest_record_scanner_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// latest_record_scanner_top_test
// Streams slotted flash images into the scanner: good records, records with
// a broken magic, version or crc, noise, truncated tail slots and an image
// past the slot limit, under several magic and version settings, with random
// gaps on both channels and one long result back-pressure stretch.
// ----------------------------------------------------------------------------
module latest_record_scanner_top_test;

   import lrs_pkg::*;
   import lrs_test_pkg::*;

   typedef enum int {
      SLOT_GOOD,
      SLOT_BAD_MAGIC,
      SLOT_BAD_VERSION,
      SLOT_BAD_CRC,
      SLOT_BAD_BODY,
      SLOT_NOISE
   } slot_kind_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_index;
   logic [31:0] csr_wr_data;

   lrs_req_if req ();
   lrs_rsp_if rsp ();

   int          mismatch_count;
   int          scans_pending;

   logic [31:0] cur_magic;
   logic [7:0]  cur_version;
   logic [7:0]  image_q[$];
   bit          tx_steady;
   bit          rx_steady;
   int          hold_cycles = 0;
   int          bytes_sent = 0;
   int          images_sent = 0;

   latest_record_scanner_top uut (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   latest_record_scanner_checker scan_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req),
      .rsp_mon        (rsp),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .scans_pending  (scans_pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic slot_kind_type pick_kind();
      int r;
      r = $urandom_range(0, 19);
      if (r < 13) return SLOT_GOOD;
      if (r < 15) return SLOT_BAD_MAGIC;
      if (r < 16) return SLOT_BAD_VERSION;
      if (r < 17) return SLOT_BAD_CRC;
      if (r < 18) return SLOT_BAD_BODY;
      return SLOT_NOISE;
   endfunction

   function automatic logic [31:0] pick_word();
      int r;
      r = $urandom_range(0, 5);
      if (r == 0) return 32'h0000_0000;
      if (r == 1) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   task automatic append_slot(slot_kind_type kind, logic [31:0] seq, logic [7:0] att,
                              logic [31:0] lock, logic [31:0] boots);
      logic [7:0]  rec [SLOT_BYTES_DEF];
      logic [15:0] crc;
      int          pos;
      foreach (rec[i]) rec[i] = 8'($urandom);
      if (kind != SLOT_NOISE) begin
         for (int i = 0; i < 4; i++) begin
            rec[i]               = cur_magic[8*i +: 8];
            rec[OFS_SEQ + i]     = seq[8*i +: 8];
            rec[OFS_LOCKOUT + i] = lock[8*i +: 8];
            rec[OFS_BOOTS + i]   = boots[8*i +: 8];
         end
         rec[OFS_VERSION]  = cur_version;
         rec[OFS_ATTEMPTS] = att;
         crc = CRC_INIT;
         for (int i = 0; i < CRC_SPAN; i++) crc = crc_ccitt_next(crc, rec[i]);
         rec[OFS_CRC_LO] = crc[7:0];
         rec[OFS_CRC_HI] = crc[15:8];
      end
      case (kind)
         SLOT_BAD_MAGIC:   pos = $urandom_range(0, 3);
         SLOT_BAD_VERSION: pos = OFS_VERSION;
         SLOT_BAD_CRC:     pos = $urandom_range(OFS_CRC_LO, OFS_CRC_HI);
         SLOT_BAD_BODY:    pos = $urandom_range(OFS_SEQ, CRC_SPAN - 1);
         default:          pos = -1;
      endcase
      if (pos >= 0) rec[pos] ^= 8'(1 << $urandom_range(0, 7));
      foreach (rec[i]) image_q.push_back(rec[i]);
   endtask

   // good record cut short, so the scanner must drop it
   task automatic append_truncated(int keep);
      append_slot(SLOT_GOOD, $urandom, 8'($urandom), $urandom, $urandom);
      repeat (SLOT_BYTES_DEF - keep) void'(image_q.pop_back());
   endtask

   task automatic append_random_image(int max_slots);
      int slots;
      int tail;
      slots = $urandom_range(0, max_slots);
      tail  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, SLOT_BYTES_DEF - 1) : 0;
      if (slots == 0 && tail == 0) tail = $urandom_range(1, SLOT_BYTES_DEF - 1);
      repeat (slots) begin
         append_slot(pick_kind(),
                     ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 7)) : $urandom,
                     8'($urandom), $urandom, $urandom);
      end
      if (tail > 0) begin
         if ($urandom_range(0, 1) == 0) begin
            append_truncated(tail);
         end else begin
            repeat (tail) image_q.push_back(8'($urandom));
         end
      end
   endtask

   // sends the queued image, final flag on its last byte
   task automatic send_image();
      int gap;
      for (int i = 0; i < image_q.size(); i++) begin
         gap = tx_steady ? 0 : pick_gap();
         if (gap > 0) begin
            req.valid      <= 1'b0;
            req.image_byte <= 8'($urandom);
            req.final_byte <= 1'($urandom);
            repeat (gap) @(negedge clock);
         end
         req.valid      <= 1'b1;
         req.image_byte <= image_q[i];
         req.final_byte <= (i == image_q.size() - 1);
         @(posedge clock);
         while (!req.ready) @(posedge clock);
         @(negedge clock);
      end
      bytes_sent += image_q.size();
      images_sent++;
      image_q.delete();
   endtask

   task automatic settle();
      req.valid <= 1'b0;
      @(negedge clock);
      while (scans_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [31:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= $urandom;
      @(negedge clock);
      if (idx == CSR_MAGIC) begin
         cur_magic = value;
      end else begin
         cur_version = value[7:0];
      end
   endtask

   initial begin : result_sink
      int stall_left;
      rsp.ready  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp.ready <= 1'b0;
            hold_cycles--;
         end else if (stall_left > 0) begin
            rsp.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp.ready <= 1'b1;
            if (!rx_steady) stall_left = pick_gap();
         end
      end
   end

   initial begin : stimulus
      int base_bytes;
      int base_images;
      reset          = 1'b1;
      req.valid      = 1'b0;
      req.image_byte = 8'h00;
      req.final_byte = 1'b0;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_MAGIC;
      csr_wr_data    = 32'h0;
      cur_magic      = 32'h0;
      cur_version    = 8'h00;
      tx_steady      = 1'b1;
      rx_steady      = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // magic and version still at their reset values
      image_q.push_back(8'hFF);
      send_image();
      append_slot(SLOT_GOOD, 32'd5, 8'd1, 32'd2, 32'd3);
      send_image();
      settle();

      write_reg(CSR_MAGIC, 32'hFFFF_FFFF);
      write_reg(CSR_VERSION, 32'hFFFF_FFFF);
      append_slot(SLOT_GOOD, '1, '1, '1, '1);
      send_image();
      // tie on sequence, an older record, then a truncated one
      append_slot(SLOT_GOOD, 32'd7, 8'd0, 32'd0, 32'd0);
      append_slot(SLOT_GOOD, 32'd7, 8'd9, 32'd9, 32'd9);
      append_slot(SLOT_GOOD, 32'd3, 8'd1, 32'd1, 32'd1);
      append_truncated(20);
      send_image();
      // every defect on records newer than the one good record
      append_slot(SLOT_GOOD, 32'd1, 8'h5A, 32'h1234_5678, 32'h0BAD_F00D);
      repeat (4) append_slot(SLOT_BAD_MAGIC, 32'd50, 8'd0, 32'd0, 32'd0);
      append_slot(SLOT_BAD_VERSION, 32'd50, 8'd0, 32'd0, 32'd0);
      repeat (2) append_slot(SLOT_BAD_CRC, 32'd50, 8'd0, 32'd0, 32'd0);
      append_slot(SLOT_BAD_BODY, 32'd50, 8'd0, 32'd0, 32'd0);
      append_slot(SLOT_NOISE, 32'd50, 8'd0, 32'd0, 32'd0);
      send_image();
      append_truncated(10);
      send_image();
      settle();

      // full slot range, winner in the last slot, newer record past the limit
      write_reg(CSR_MAGIC, $urandom);
      write_reg(CSR_VERSION, $urandom);
      rx_steady = 1'b0;
      for (int s = 0; s < MAX_SLOTS_DEF - 1; s++) begin
         append_slot(pick_kind(), 32'($urandom_range(0, 32'h7FFF_FFFF)),
                     8'($urandom), $urandom, $urandom);
      end
      append_slot(SLOT_GOOD, 32'hFFFF_FFF0, 8'($urandom), $urandom, $urandom);
      append_slot(SLOT_GOOD, 32'hFFFF_FFFF, 8'($urandom), $urandom, $urandom);
      repeat (5) image_q.push_back(8'($urandom));
      send_image();
      settle();

      // results back up while bytes keep coming
      rx_steady   = 1'b1;
      hold_cycles = 400;
      repeat (30) begin
         append_random_image(0);
         send_image();
      end
      settle();

      base_bytes  = bytes_sent;
      base_images = images_sent;
      while (bytes_sent - base_bytes < 1450 || images_sent - base_images < 40) begin
         if ($urandom_range(0, 3) != 0) write_reg(CSR_MAGIC, pick_word());
         if ($urandom_range(0, 3) != 0) write_reg(CSR_VERSION, pick_word());
         tx_steady = ($urandom_range(0, 3) == 0);
         rx_steady = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(3, 8)) begin
            append_random_image(($urandom_range(0, 3) == 0) ? 6 : 2);
            send_image();
         end
         settle();
      end

      repeat (16) @(negedge clock);
      if (mismatch_count == 0 && scans_pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
